FILE: src/assert_macros.svh
// Assertion macros shared by the RTL that checks itself.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property sampled on clk, suspended while in reset.
`define STT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication sampled on clk, suspended while in reset.
`define STT_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

FILE: src/stt_pkg.sv
// Types, constants and helper functions of the source text tokenizer.
package stt_pkg;

    localparam int POS_BITS     = 24;
    localparam int LEN_BITS     = POS_BITS + 1;
    localparam int LINE_BITS    = 24;
    localparam int HEX_BITS     = 64;
    localparam int MAX_RES      = 3;
    localparam int QDEPTH       = 2;
    localparam int QPTR_BITS    = $clog2(QDEPTH);
    localparam int QCNT_BITS    = $clog2(QDEPTH + 1);
    localparam int CFG_IDX_BITS = 4;

    localparam logic [LINE_BITS-1:0] LINE_MAX = {LINE_BITS{1'b1}};

    localparam logic [CFG_IDX_BITS-1:0] CFG_COUNT_CR   = CFG_IDX_BITS'(0);
    localparam logic [CFG_IDX_BITS-1:0] CFG_FIRST_LINE = CFG_IDX_BITS'(1);

    localparam logic [7:0] CH_CR     = 8'h0d;
    localparam logic [7:0] CH_LF     = 8'h0a;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_DOT    = 8'h2e;
    localparam logic [7:0] CH_X      = 8'h78;
    localparam logic [7:0] CH_MINUS  = 8'h2d;
    localparam logic [7:0] CH_SLASH  = 8'h2f;
    localparam logic [7:0] CH_STAR   = 8'h2a;
    localparam logic [7:0] CH_UNDER  = 8'h5f;
    localparam logic [7:0] CH_BSLASH = 8'h5c;

    typedef enum logic [2:0] {
        K_ERROR  = 3'd0,
        K_END    = 3'd1,
        K_IDENT  = 3'd2,
        K_DELIM  = 3'd3,
        K_STRING = 3'd4,
        K_NUMBER = 3'd5
    } kind_t;

    typedef enum logic [14:0] {
        M_IDLE       = 15'b000000000000001,
        M_SLASH      = 15'b000000000000010,
        M_LINE       = 15'b000000000000100,
        M_BLOCK      = 15'b000000000001000,
        M_BLOCK_STAR = 15'b000000000010000,
        M_STR_D      = 15'b000000000100000,
        M_STR_D_ESC  = 15'b000000001000000,
        M_STR_S      = 15'b000000010000000,
        M_STR_S_ESC  = 15'b000000100000000,
        M_MINUS      = 15'b000001000000000,
        M_NUM_LEAD   = 15'b000010000000000,
        M_NUM_DEC    = 15'b000100000000000,
        M_HEX        = 15'b001000000000000,
        M_IDENT      = 15'b010000000000000,
        M_HALT       = 15'b100000000000000
    } mode_t;

    typedef struct packed {
        kind_t                 kind;
        logic [POS_BITS-1:0]   offset;
        logic [LEN_BITS-1:0]   length;
        logic [LINE_BITS-1:0]  line;
        logic [HEX_BITS-1:0]   hexv;
        logic                  is_hex;
    } res_t;

    typedef struct packed {
        logic [1:0]             count;
        res_t [MAX_RES-1:0]     slot;
    } bundle_t;

    typedef struct packed {
        logic full;
        logic empty;
    } qstat_t;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= 8'h61) && (c <= 8'h7a)) || ((c >= 8'h41) && (c <= 8'h5a));
    endfunction

    // {valid, nibble}
    function automatic logic [4:0] hex_nib(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (is_digit(c))
            r = {1'b1, 4'(c - 8'h30)};
        else if ((c >= 8'h61) && (c <= 8'h66))
            r = {1'b1, 4'(c - 8'h57)};
        else if ((c >= 8'h41) && (c <= 8'h46))
            r = {1'b1, 4'(c - 8'h37)};
        return r;
    endfunction

    // Length with one wrap of the position counter allowed.
    function automatic logic [LEN_BITS-1:0] span(input logic [LEN_BITS-1:0] stop,
                                                 input logic [POS_BITS-1:0] start);
        logic [LEN_BITS-1:0] s;
        s = {1'b0, start};
        if (stop >= s)
            return stop - s;
        return stop + (LEN_BITS'(1) << POS_BITS) - s;
    endfunction

    function automatic res_t mk_res(input kind_t k, input logic [POS_BITS-1:0] off,
                                    input logic [LEN_BITS-1:0] len,
                                    input logic [LINE_BITS-1:0] ln,
                                    input logic [HEX_BITS-1:0] hv, input logic hx);
        res_t r;
        r.kind   = k;
        r.offset = off;
        r.length = len;
        r.line   = ln;
        r.hexv   = hv;
        r.is_hex = hx;
        return r;
    endfunction

endpackage

FILE: src/stt_if.sv
// Handshake channel interfaces: text input, token output, register writes.
interface stt_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       end_of_text;
    modport source (output valid, text_byte, end_of_text, input ready);
    modport sink   (input valid, text_byte, end_of_text, output ready);
endinterface

interface stt_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  token_kind;
    logic [23:0] token_offset;
    logic [24:0] token_length;
    logic [23:0] line_number;
    logic [63:0] hex_value;
    logic        is_hex;
    logic        last_of_run;
    modport source (output valid, token_kind, token_offset, token_length, line_number,
                    hex_value, is_hex, last_of_run, input ready);
    modport sink   (input valid, token_kind, token_offset, token_length, line_number,
                    hex_value, is_hex, last_of_run, output ready);
endinterface

interface stt_cfg_if;
    logic       valid;
    logic       ready;
    logic [3:0] index;
    logic       data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

FILE: src/source_text_tokenizer_top.sv
// Top level of the source text tokenizer.
//  channel    dir  payload                                             accept
//  item_in    in   text_byte, end_of_text                              valid && ready
//  token_out  out  kind, offset, length, line, hex, is_hex, last       valid && ready
//  cfg        in   index (0 count_lone_cr, 1 first_line_number), data  valid && ready
// One byte per cycle enters the scanner while the queue is not full; its tokens (0 to 3)
// leave one per cycle from the output register while token_out is ready.
// A two-entry bundle queue decouples scanning from output stalls.
// Reset clears all scanner state; no clearing pass. cfg is always ready.
`include "assert_macros.svh"

module source_text_tokenizer_top
    import stt_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    stt_in_if.sink    item_in,
    stt_cfg_if.sink   cfg,
    stt_out_if.source token_out
);

    logic    push;
    logic    pop;
    bundle_t push_data;
    bundle_t head;
    qstat_t  qstat;

    stt_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .item_in   (item_in),
        .cfg       (cfg),
        .qstat     (qstat),
        .push      (push),
        .push_data (push_data)
    );

    stt_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head      (head),
        .qstat     (qstat)
    );

    stt_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .qstat     (qstat),
        .pop       (pop),
        .token_out (token_out)
    );

    `STT_ASSERT_IMP(a_end_last, token_out.valid && token_out.token_kind == K_END,
                    token_out.last_of_run, "end item not last of its run")
    `STT_ASSERT_IMP(a_hex_num, token_out.valid && token_out.is_hex,
                    token_out.token_kind == K_NUMBER, "hex flag on non-number")
    `STT_ASSERT_IMP(a_err_zero, token_out.valid && token_out.token_kind == K_ERROR,
                    token_out.token_offset == '0 && token_out.token_length == '0,
                    "error item carries position")
    `STT_ASSERT_IMP(a_no_push_full, push, !qstat.full, "push into full queue")

endmodule

FILE: src/stt_front.sv
// Front end: scans one byte per cycle while the queue is not full and queues the tokens it produces.
module stt_front
    import stt_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    stt_in_if.sink  item_in,
    stt_cfg_if.sink cfg,
    input  qstat_t  qstat,
    output logic    push,
    output bundle_t push_data
);

    mode_t                mode_reg, mode_next;
    logic [POS_BITS-1:0]  pos_reg, pos_next;
    logic [POS_BITS-1:0]  tstart_reg, tstart_next;
    logic [LINE_BITS-1:0] lcnt_reg, lcnt_next;
    logic [LINE_BITS-1:0] tline_reg, tline_next;
    logic                 prevcr_reg, prevcr_next;
    logic [HEX_BITS-1:0]  hex_reg, hex_next;
    logic                 dot_reg, dot_next;
    logic                 cnt_cr_reg, first_reg;

    logic                 accept;
    logic [7:0]           c;
    logic [LEN_BITS-1:0]  pos1;
    logic [LINE_BITS-1:0] cur_line;
    logic [LINE_BITS:0]   line_sum;
    bundle_t              bun;
    logic                 do_idle;
    logic [4:0]           nib;

    assign accept    = item_in.valid && item_in.ready;
    assign item_in.ready = !qstat.full;
    assign cfg.ready = 1'b1;
    assign c         = item_in.text_byte;
    assign pos1      = {1'b0, pos_reg} + LEN_BITS'(1);
    assign line_sum  = {1'b0, lcnt_reg} + {{LINE_BITS{1'b0}}, first_reg};
    assign cur_line  = line_sum[LINE_BITS] ? LINE_MAX : line_sum[LINE_BITS-1:0];
    assign nib       = hex_nib(c);

    always_comb
    begin
        mode_next   = mode_reg;
        tstart_next = tstart_reg;
        tline_next  = tline_reg;
        hex_next    = hex_reg;
        dot_next    = dot_reg;
        lcnt_next   = lcnt_reg;
        prevcr_next = prevcr_reg;
        pos_next    = pos1[POS_BITS-1:0];
        bun         = '0;
        do_idle     = 1'b0;

        case (mode_reg)
            M_SLASH:
            begin
                if (c == CH_SLASH)
                    mode_next = M_LINE;
                else if (c == CH_STAR)
                    mode_next = M_BLOCK;
                else
                begin
                    bun.slot[bun.count] = mk_res(K_DELIM, tstart_reg,
                        span({1'b0, tstart_reg} + LEN_BITS'(1), tstart_reg), tline_reg, '0, 1'b0);
                    bun.count = bun.count + 2'd1;
                    do_idle = 1'b1;
                end
            end
            M_LINE:
            begin
                if (c == CH_CR || c == CH_LF)
                    mode_next = M_IDLE;
            end
            M_BLOCK:
            begin
                if (c == CH_STAR)
                    mode_next = M_BLOCK_STAR;
            end
            M_BLOCK_STAR:
            begin
                if (c == CH_SLASH)
                    mode_next = M_IDLE;
                else if (c != CH_STAR)
                    mode_next = M_BLOCK;
            end
            M_STR_D, M_STR_S:
            begin
                if (c == CH_BSLASH)
                    mode_next = (mode_reg == M_STR_D) ? M_STR_D_ESC : M_STR_S_ESC;
                else if ((mode_reg == M_STR_D && c == CH_DQUOTE) ||
                         (mode_reg == M_STR_S && c == CH_SQUOTE))
                begin
                    bun.slot[bun.count] = mk_res(K_STRING, tstart_reg, span(pos1 - LEN_BITS'(1),
                        tstart_reg), tline_reg, '0, 1'b0);
                    bun.count = bun.count + 2'd1;
                    mode_next = M_IDLE;
                end
            end
            M_STR_D_ESC:
            begin
                if (c != CH_BSLASH)
                    mode_next = M_STR_D;
            end
            M_STR_S_ESC:
            begin
                if (c != CH_BSLASH)
                    mode_next = M_STR_S;
            end
            M_MINUS:
            begin
                if (is_digit(c))
                begin
                    mode_next = M_NUM_LEAD;
                    dot_next  = 1'b0;
                end
                else
                begin
                    bun.slot[bun.count] = mk_res(K_DELIM, tstart_reg,
                        span({1'b0, tstart_reg} + LEN_BITS'(1), tstart_reg), tline_reg, '0, 1'b0);
                    bun.count = bun.count + 2'd1;
                    do_idle = 1'b1;
                end
            end
            M_NUM_LEAD, M_NUM_DEC:
            begin
                if (mode_reg == M_NUM_LEAD && c == CH_X)
                begin
                    mode_next   = M_HEX;
                    tstart_next = pos1[POS_BITS-1:0];
                    hex_next    = '0;
                end
                else
                begin
                    mode_next = M_NUM_DEC;
                    if (is_digit(c))
                        mode_next = M_NUM_DEC;
                    else if (c == CH_DOT)
                    begin
                        if (dot_reg)
                        begin
                            bun.slot[bun.count] = mk_res(K_ERROR, '0, '0, '0, '0, 1'b0);
                            bun.count = bun.count + 2'd1;
                            mode_next = M_HALT;
                        end
                        else
                            dot_next = 1'b1;
                    end
                    else
                    begin
                        bun.slot[bun.count] = mk_res(K_NUMBER, tstart_reg, span(pos1 - LEN_BITS'(1),
                            tstart_reg), tline_reg, '0, 1'b0);
                        bun.count = bun.count + 2'd1;
                        do_idle = 1'b1;
                    end
                end
            end
            M_HEX:
            begin
                if (nib[4])
                    hex_next = {hex_reg[HEX_BITS-5:0], nib[3:0]};
                else
                begin
                    bun.slot[bun.count] = mk_res(K_NUMBER, tstart_reg, span(pos1 - LEN_BITS'(1),
                        tstart_reg), tline_reg, hex_reg, 1'b1);
                    bun.count = bun.count + 2'd1;
                    do_idle = 1'b1;
                end
            end
            M_IDENT:
            begin
                if (!(is_alpha(c) || is_digit(c) || c == CH_UNDER))
                begin
                    bun.slot[bun.count] = mk_res(K_IDENT, tstart_reg, span(pos1 - LEN_BITS'(1),
                        tstart_reg), tline_reg, '0, 1'b0);
                    bun.count = bun.count + 2'd1;
                    do_idle = 1'b1;
                end
            end
            M_HALT:
            begin
                mode_next = M_HALT;
            end
            default:
            begin
                do_idle = 1'b1;
            end
        endcase

        // Byte scanned afresh between tokens.
        if (do_idle)
        begin
            mode_next = M_IDLE;
            if (!(c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF))
            begin
                tstart_next = pos_reg;
                tline_next  = cur_line;
                if (c == CH_SLASH)
                    mode_next = M_SLASH;
                else if (c == CH_DQUOTE)
                begin
                    mode_next   = M_STR_D;
                    tstart_next = pos1[POS_BITS-1:0];
                end
                else if (c == CH_SQUOTE)
                begin
                    mode_next   = M_STR_S;
                    tstart_next = pos1[POS_BITS-1:0];
                end
                else if (is_digit(c))
                begin
                    mode_next = M_NUM_LEAD;
                    dot_next  = 1'b0;
                end
                else if (c == CH_MINUS)
                    mode_next = M_MINUS;
                else if (is_alpha(c))
                    mode_next = M_IDENT;
                else
                begin
                    bun.slot[bun.count] = mk_res(K_DELIM, pos_reg, LEN_BITS'(1), cur_line,
                                                 '0, 1'b0);
                    bun.count = bun.count + 2'd1;
                end
            end
        end

        if (c == CH_CR)
        begin
            if (cnt_cr_reg && lcnt_reg != LINE_MAX)
                lcnt_next = lcnt_reg + LINE_BITS'(1);
            prevcr_next = 1'b1;
        end
        else
        begin
            if (c == CH_LF && !(prevcr_reg && cnt_cr_reg) && lcnt_reg != LINE_MAX)
                lcnt_next = lcnt_reg + LINE_BITS'(1);
            prevcr_next = 1'b0;
        end

        if (item_in.end_of_text)
        begin
            case (mode_next)
                M_SLASH, M_MINUS:
                begin
                    bun.slot[bun.count] = mk_res(K_DELIM, tstart_next,
                        span({1'b0, tstart_next} + LEN_BITS'(1), tstart_next), tline_next,
                        '0, 1'b0);
                    bun.count = bun.count + 2'd1;
                end
                M_STR_D, M_STR_D_ESC, M_STR_S, M_STR_S_ESC:
                begin
                    bun.slot[bun.count] = mk_res(K_STRING, tstart_next, span(pos1, tstart_next),
                                                 tline_next, '0, 1'b0);
                    bun.count = bun.count + 2'd1;
                end
                M_NUM_LEAD, M_NUM_DEC:
                begin
                    bun.slot[bun.count] = mk_res(K_NUMBER, tstart_next, span(pos1, tstart_next),
                                                 tline_next, '0, 1'b0);
                    bun.count = bun.count + 2'd1;
                end
                M_HEX:
                begin
                    bun.slot[bun.count] = mk_res(K_NUMBER, tstart_next, span(pos1, tstart_next),
                                                 tline_next, hex_next, 1'b1);
                    bun.count = bun.count + 2'd1;
                end
                M_IDENT:
                begin
                    bun.slot[bun.count] = mk_res(K_IDENT, tstart_next, span(pos1, tstart_next),
                                                 tline_next, '0, 1'b0);
                    bun.count = bun.count + 2'd1;
                end
                default:
                begin
                    bun.count = bun.count;
                end
            endcase
            bun.slot[bun.count] = mk_res(K_END, '0, '0, '0, '0, 1'b0);
            bun.count = bun.count + 2'd1;
            // Back to the reset state for the next text.
            mode_next   = M_IDLE;
            pos_next    = '0;
            tstart_next = '0;
            lcnt_next   = '0;
            tline_next  = '0;
            prevcr_next = 1'b0;
            hex_next    = '0;
            dot_next    = 1'b0;
        end
    end

    assign push      = accept && (bun.count != 2'd0);
    assign push_data = bun;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= M_IDLE;
            pos_reg    <= '0;
            tstart_reg <= '0;
            lcnt_reg   <= '0;
            tline_reg  <= '0;
            prevcr_reg <= 1'b0;
            hex_reg    <= '0;
            dot_reg    <= 1'b0;
            cnt_cr_reg <= 1'b1;
            first_reg  <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                mode_reg   <= mode_next;
                pos_reg    <= pos_next;
                tstart_reg <= tstart_next;
                lcnt_reg   <= lcnt_next;
                tline_reg  <= tline_next;
                prevcr_reg <= prevcr_next;
                hex_reg    <= hex_next;
                dot_reg    <= dot_next;
            end
            if (cfg.valid && cfg.ready)
            begin
                if (cfg.index == CFG_COUNT_CR)
                    cnt_cr_reg <= cfg.data;
                else if (cfg.index == CFG_FIRST_LINE)
                    first_reg <= cfg.data;
            end
        end
    end

endmodule

FILE: src/stt_fifo.sv
// Short queue of per-byte token bundles between the scanner and the output.
module stt_fifo
    import stt_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  bundle_t push_data,
    input  logic    pop,
    output bundle_t head,
    output qstat_t  qstat
);

    bundle_t              mem_reg [QDEPTH];
    logic [QPTR_BITS-1:0] wr_reg, rd_reg;
    logic [QCNT_BITS-1:0] cnt_reg;

    assign head        = mem_reg[rd_reg];
    assign qstat.full  = (cnt_reg == QCNT_BITS'(QDEPTH));
    assign qstat.empty = (cnt_reg == '0);

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wr_reg <= (wr_reg == QPTR_BITS'(QDEPTH - 1)) ? '0 : wr_reg + QPTR_BITS'(1);
            if (pop)
                rd_reg <= (rd_reg == QPTR_BITS'(QDEPTH - 1)) ? '0 : rd_reg + QPTR_BITS'(1);
            if (push && !pop)
                cnt_reg <= cnt_reg + QCNT_BITS'(1);
            else if (pop && !push)
                cnt_reg <= cnt_reg - QCNT_BITS'(1);
        end
    end

endmodule

FILE: src/stt_back.sv
// Back end: unpacks queued bundles into single tokens on the output register.
module stt_back
    import stt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  bundle_t    head,
    input  qstat_t     qstat,
    output logic       pop,
    stt_out_if.source  token_out
);

    logic [1:0] idx_reg;
    logic       ov_reg;
    res_t       res_reg;
    logic       last_reg;
    logic       load;
    logic       at_last;

    assign load    = !qstat.empty && (!ov_reg || token_out.ready);
    assign at_last = (idx_reg == head.count - 2'd1);
    assign pop     = load && at_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
            ov_reg  <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                ov_reg  <= 1'b1;
                idx_reg <= at_last ? 2'd0 : idx_reg + 2'd1;
            end
            else if (token_out.ready)
                ov_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg  <= head.slot[idx_reg];
            last_reg <= at_last;
        end
    end

    assign token_out.valid        = ov_reg;
    assign token_out.token_kind   = res_reg.kind;
    assign token_out.token_offset = res_reg.offset;
    assign token_out.token_length = res_reg.length;
    assign token_out.line_number  = res_reg.line;
    assign token_out.hex_value    = res_reg.hexv;
    assign token_out.is_hex       = res_reg.is_hex;
    assign token_out.last_of_run  = last_reg;

endmodule

FILE: tb/sv/tb_source_text_tokenizer_top.sv
// Testbench for the source text tokenizer: directed and random texts against a scanner model.
`timescale 1ns / 1ps

module tb_source_text_tokenizer_top;
    import stt_pkg::*;

    logic clk;
    logic rst_n;

    stt_in_if  item_in ();
    stt_out_if token_out ();
    stt_cfg_if cfg ();

    source_text_tokenizer_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .item_in   (item_in),
        .cfg       (cfg),
        .token_out (token_out)
    );

    typedef enum int {
        S_IDLE, S_SLASH, S_LINE, S_BLOCK, S_BLOCK_STAR, S_STR_D, S_STR_D_ESC,
        S_STR_S, S_STR_S_ESC, S_MINUS, S_NUM_LEAD, S_NUM_DEC, S_HEX, S_IDENT, S_HALT
    } scan_state_t;

    typedef struct {
        kind_t       kind;
        logic [23:0] offset;
        logic [24:0] length;
        logic [23:0] line;
        logic [63:0] hexv;
        logic        is_hex;
        logic        last;
    } token_t;

    token_t tokens_due[$];
    int     fail_count;
    longint cycle_count;

    // scanner model state
    logic        lone_cr_breaks;
    logic        first_line;
    scan_state_t mode;
    logic [23:0] cur_pos;
    logic [23:0] tok_start;
    logic [23:0] line_cnt;
    logic [23:0] tok_line;
    logic        prev_cr;
    logic [63:0] hex_acc;
    logic        dot_seen;

    function automatic logic digit_ch(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic alpha_ch(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic logic [24:0] token_span(logic [24:0] stop);
        if (stop >= {1'b0, tok_start})
            return stop - {1'b0, tok_start};
        return stop + 25'h1000000 - {1'b0, tok_start};
    endfunction

    function automatic logic [23:0] line_now();
        logic [24:0] v;
        v = {1'b0, line_cnt} + first_line;
        return v[24] ? 24'hffffff : v[23:0];
    endfunction

    function automatic void push_token(kind_t k, logic [23:0] off, logic [24:0] len,
                                       logic [23:0] ln, logic [63:0] hv, logic hx);
        token_t t;
        t.kind = k; t.offset = off; t.length = len; t.line = ln;
        t.hexv = hv; t.is_hex = hx; t.last = 1'b0;
        tokens_due.push_back(t);
    endfunction

    function automatic void clear_scanner();
        mode = S_IDLE; cur_pos = '0; tok_start = '0; line_cnt = '0;
        tok_line = '0; prev_cr = 1'b0; hex_acc = '0; dot_seen = 1'b0;
    endfunction

    function automatic void start_token(logic [7:0] c, logic [23:0] p);
        mode = S_IDLE;
        if (c == " " || c == CH_TAB || c == CH_CR || c == CH_LF)
            return;
        tok_start = p;
        tok_line = line_now();
        if (c == CH_SLASH) mode = S_SLASH;
        else if (c == CH_DQUOTE) begin mode = S_STR_D; tok_start = p + 1; end
        else if (c == CH_SQUOTE) begin mode = S_STR_S; tok_start = p + 1; end
        else if (digit_ch(c)) begin mode = S_NUM_LEAD; dot_seen = 1'b0; end
        else if (c == CH_MINUS) mode = S_MINUS;
        else if (alpha_ch(c)) mode = S_IDENT;
        else push_token(K_DELIM, p, 25'd1, tok_line, '0, 1'b0);
    endfunction

    function automatic void predict_tokens(logic [7:0] c, logic eot);
        logic [23:0] p;
        logic [4:0]  nib;
        int          n0;
        p = cur_pos;
        n0 = tokens_due.size();
        case (mode)
            S_SLASH:
                if (c == CH_SLASH) mode = S_LINE;
                else if (c == CH_STAR) mode = S_BLOCK;
                else begin
                    push_token(K_DELIM, tok_start, 25'd1, tok_line, '0, 1'b0);
                    start_token(c, p);
                end
            S_LINE:  if (c == CH_CR || c == CH_LF) mode = S_IDLE;
            S_BLOCK: if (c == CH_STAR) mode = S_BLOCK_STAR;
            S_BLOCK_STAR:
                if (c == CH_SLASH) mode = S_IDLE;
                else if (c != CH_STAR) mode = S_BLOCK;
            S_STR_D, S_STR_S:
                if (c == CH_BSLASH) mode = (mode == S_STR_D) ? S_STR_D_ESC : S_STR_S_ESC;
                else if (c == ((mode == S_STR_D) ? CH_DQUOTE : CH_SQUOTE)) begin
                    push_token(K_STRING, tok_start, token_span({1'b0, p}), tok_line, '0, 1'b0);
                    mode = S_IDLE;
                end
            S_STR_D_ESC: if (c != CH_BSLASH) mode = S_STR_D;
            S_STR_S_ESC: if (c != CH_BSLASH) mode = S_STR_S;
            S_MINUS:
                if (digit_ch(c)) begin mode = S_NUM_LEAD; dot_seen = 1'b0; end
                else begin
                    push_token(K_DELIM, tok_start, 25'd1, tok_line, '0, 1'b0);
                    start_token(c, p);
                end
            S_NUM_LEAD, S_NUM_DEC:
                if (mode == S_NUM_LEAD && c == CH_X) begin
                    mode = S_HEX; tok_start = p + 1; hex_acc = '0;
                end else begin
                    mode = S_NUM_DEC;
                    if (c == CH_DOT) begin
                        if (dot_seen) begin
                            push_token(K_ERROR, '0, '0, '0, '0, 1'b0);
                            mode = S_HALT;
                        end else dot_seen = 1'b1;
                    end else if (!digit_ch(c)) begin
                        push_token(K_NUMBER, tok_start, token_span({1'b0, p}), tok_line,
                                   '0, 1'b0);
                        start_token(c, p);
                    end
                end
            S_HEX: begin
                nib = hex_nib(c);
                if (nib[4]) hex_acc = {hex_acc[59:0], nib[3:0]};
                else begin
                    push_token(K_NUMBER, tok_start, token_span({1'b0, p}), tok_line,
                               hex_acc, 1'b1);
                    start_token(c, p);
                end
            end
            S_IDENT:
                if (!(alpha_ch(c) || digit_ch(c) || c == CH_UNDER)) begin
                    push_token(K_IDENT, tok_start, token_span({1'b0, p}), tok_line, '0, 1'b0);
                    start_token(c, p);
                end
            S_HALT: ;
            default: start_token(c, p);
        endcase
        if (c == CH_CR) begin
            if (lone_cr_breaks && line_cnt != 24'hffffff) line_cnt++;
            prev_cr = 1'b1;
        end else begin
            if (c == CH_LF && !(prev_cr && lone_cr_breaks) && line_cnt != 24'hffffff)
                line_cnt++;
            prev_cr = 1'b0;
        end
        cur_pos = p + 1;
        if (eot) begin
            case (mode)
                S_SLASH, S_MINUS:
                    push_token(K_DELIM, tok_start, 25'd1, tok_line, '0, 1'b0);
                S_STR_D, S_STR_D_ESC, S_STR_S, S_STR_S_ESC:
                    push_token(K_STRING, tok_start, token_span({1'b0, p} + 1), tok_line,
                               '0, 1'b0);
                S_NUM_LEAD, S_NUM_DEC:
                    push_token(K_NUMBER, tok_start, token_span({1'b0, p} + 1), tok_line,
                               '0, 1'b0);
                S_HEX:
                    push_token(K_NUMBER, tok_start, token_span({1'b0, p} + 1), tok_line,
                               hex_acc, 1'b1);
                S_IDENT:
                    push_token(K_IDENT, tok_start, token_span({1'b0, p} + 1), tok_line,
                               '0, 1'b0);
                default: ;
            endcase
            push_token(K_END, '0, '0, '0, '0, 1'b0);
            clear_scanner();
        end
        if (tokens_due.size() > n0)
            tokens_due[tokens_due.size() - 1].last = 1'b1;
    endfunction

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    // output side: random stalls, check each token against the oldest prediction
    int stall_left;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            token_out.ready <= 1'b0;
            stall_left = 0;
        end else begin
            if (token_out.valid && token_out.ready) begin
                if (tokens_due.size() == 0) begin
                    $error("token with nothing expected: kind %0d", token_out.token_kind);
                    fail_count++;
                end else begin
                    token_t e;
                    e = tokens_due.pop_front();
                    if (token_out.token_kind !== e.kind) begin
                        $error("token_kind expected %0d got %0d", e.kind, token_out.token_kind);
                        fail_count++;
                    end
                    if (token_out.token_offset !== e.offset) begin
                        $error("token_offset expected %0d got %0d", e.offset,
                               token_out.token_offset);
                        fail_count++;
                    end
                    if (token_out.token_length !== e.length) begin
                        $error("token_length expected %0d got %0d", e.length,
                               token_out.token_length);
                        fail_count++;
                    end
                    if (token_out.line_number !== e.line) begin
                        $error("line_number expected %0d got %0d", e.line,
                               token_out.line_number);
                        fail_count++;
                    end
                    if (token_out.hex_value !== e.hexv) begin
                        $error("hex_value expected %h got %h", e.hexv, token_out.hex_value);
                        fail_count++;
                    end
                    if (token_out.is_hex !== e.is_hex) begin
                        $error("is_hex expected %0d got %0d", e.is_hex, token_out.is_hex);
                        fail_count++;
                    end
                    if (token_out.last_of_run !== e.last) begin
                        $error("last_of_run expected %0d got %0d", e.last,
                               token_out.last_of_run);
                        fail_count++;
                    end
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                token_out.ready <= 1'b0;
            end else begin
                stall_left = gap_len();
                token_out.ready <= (stall_left == 0);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > 400000) begin
            $display("source_text_tokenizer_top: mismatch");
            $finish;
        end
    end

    // valid stays high between items when there is no gap
    task automatic send_byte(input logic [7:0] c, input logic eot);
        int g;
        g = gap_len();
        if (g > 0) begin
            item_in.valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        item_in.valid       <= 1'b1;
        item_in.text_byte   <= c;
        item_in.end_of_text <= eot;
        do @(posedge clk); while (!item_in.ready);
        predict_tokens(c, eot);
    endtask

    task automatic send_text(input string s, input logic eot);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i], eot && (i == s.len() - 1));
    endtask

    task automatic drain();
        item_in.valid <= 1'b0;
        while (tokens_due.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic write_reg(input logic [3:0] idx, input logic val);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= val;
        do @(posedge clk); while (!cfg.ready);
        cfg.valid <= 1'b0;
        if (idx == CFG_COUNT_CR) lone_cr_breaks = val;
        else first_line = val;
        @(posedge clk);
    endtask

    task automatic test_directed();
        send_text("ab_9 = \"x\\\"y\"; 'q' -7.5 -x / ", 1'b1);
        send_text("// c\r\n/* a ** b */0x1fAz 0x 12.3.4 junk", 1'b1);
        send_text("1..2", 1'b0);
        send_text("q\r\r\n\n\xff\x80\x00~ -0xff 7", 1'b1);
        send_text("/*open", 1'b1);
        send_text("\"tail\\", 1'b1);
        send_text("0x0123456789abcdef01", 1'b1);
        send_byte("-", 1'b1);
        send_byte("/", 1'b1);
        drain();
    endtask

    task automatic test_random(input int n);
        string frag[] = '{"abc", "x_1", " ", "\t", "\r", "\n", "\r\n", "\"s\\\"t\"",
                          "'u'", "-3", "4.25", "9x", "0xBEEF", "// z\n", "/* * */",
                          "/", "-", "(", ";", "1.2.", "\\", "'", "\""};
        int sent;
        sent = 0;
        while (sent < n) begin
            if ($urandom_range(0, 3) == 0) begin
                send_byte(8'($urandom), $urandom_range(0, 30) == 0);
                sent++;
            end else begin
                string s;
                s = frag[$urandom_range(0, frag.size() - 1)];
                send_text(s, $urandom_range(0, 12) == 0);
                sent += s.len();
            end
        end
        send_byte(" ", 1'b1);
        drain();
    endtask

    initial
    begin
        fail_count = 0;
        cycle_count = 0;
        rst_n = 1'b0;
        item_in.valid = 1'b0;
        item_in.text_byte = '0;
        item_in.end_of_text = 1'b0;
        cfg.valid = 1'b0;
        cfg.index = '0;
        cfg.data = 1'b0;
        lone_cr_breaks = 1'b1;
        first_line = 1'b0;
        clear_scanner();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        write_reg(CFG_COUNT_CR, 1'b0);
        write_reg(CFG_FIRST_LINE, 1'b1);
        test_directed();
        test_random(50);
        write_reg(CFG_COUNT_CR, 1'b1);
        test_random(50);
        write_reg(CFG_FIRST_LINE, 1'b0);
        test_random(50);
        if (fail_count == 0)
            $display("source_text_tokenizer_top: match");
        else
            $display("source_text_tokenizer_top: mismatch");
        $finish;
    end

endmodule
